### sv/sobel_edge_threshold_macros.svh
// Assertion shorthands for the sobel_edge_threshold block.
// Each use stands on a line of its own and expands to one labeled
// concurrent assertion, checked at the rising clock edge outside reset.
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

// Same-cycle implication.
`define SET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/set_pkg.sv
`timescale 1ns / 1ps

package set_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int THR_W      = 11;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int CFG_DATA_W = 12;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 22;
    localparam int SUM_W      = 10;

    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [FW_W-1:0]  FW_RST  = 11'd640;
    localparam logic [FH_W-1:0]  FH_RST  = 12'd480;
    localparam logic [THR_W-1:0] THR_RST = 11'd100;
    localparam logic [PIX_W-1:0] BV_RST  = 8'd0;
    localparam int               MIN_DIM = 3;

    localparam logic [PIX_W-1:0] EDGE_VAL = 8'd0;
    localparam logic [PIX_W-1:0] FLAT_VAL = 8'd255;

    // x/3 == (x * 43691) >> 17 for every sum of three 8-bit channels
    localparam int                GRAY_PROD_W = 26;
    localparam logic [15:0]       GRAY_MUL    = 16'd43691;
    localparam int                GRAY_SHIFT  = 17;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2,
        REG_BORDER_VALUE   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BORDER,
        KIND_SOBEL
    } t_kind;

    typedef struct packed {
        logic             is_pixel;
        t_kind            kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### sv/set_if.sv
`timescale 1ns / 1ps

interface set_pix_if import set_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, command, red, green, blue, input ready);
    modport sink   (input valid, command, red, green, blue, output ready);
endinterface

interface set_res_if import set_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_pixel;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;

    modport source (output valid, edge_pixel, out_row, out_col, frame_last, input ready);
    modport sink   (input valid, edge_pixel, out_row, out_col, frame_last, output ready);
endinterface

interface set_cfg_if import set_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_reg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/set_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module set_div import set_pkg::*; #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_r;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W-1:0] rem_nx;

    always_comb begin
        rem_sh = {r_r, r_q[NUM_W-1]};
        fits   = rem_sh >= {1'b0, r_den};
        rem_nx = fits ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_r   <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[NUM_W-2:0], fits};
            r_r <= rem_nx;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_q;
    assign o_rem       = r_r;

endmodule

### sv/set_grad.sv
`timescale 1ns / 1ps

// Line stores, 3x3 window and Sobel kernels. Stage 1 holds the item and the
// line store read; stage 2 holds the two gradients.
module set_grad import set_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    output logic                           o_ready,
    input  t_ctl                           i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_idx,
    input  logic [PIX_W-1:0]               i_red,
    input  logic [PIX_W-1:0]               i_green,
    input  logic [PIX_W-1:0]               i_blue,
    output logic                           o_valid,
    input  logic                           i_ready,
    output t_ctl                           o_ctl,
    output logic signed [GRAD_W-1:0]       o_gx,
    output logic signed [GRAD_W-1:0]       o_gy
);

    localparam int CW = $clog2(MAX_WIDTH);

    // [2*PIX_W-1:PIX_W] previous row, [PIX_W-1:0] row before that
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];

    logic               r_v1;
    t_ctl               r_ctl1;
    logic [CW-1:0]      r_idx1;
    logic [PIX_W-1:0]   r_red;
    logic [PIX_W-1:0]   r_green;
    logic [PIX_W-1:0]   r_blue;
    logic [2*PIX_W-1:0] r_rd;
    logic [PIX_W-1:0]   r_win [6];

    logic               r_v2;
    t_ctl               r_ctl2;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;

    logic                   s1_go;
    logic [SUM_W-1:0]       rgb_sum;
    logic [GRAY_PROD_W-1:0] gray_prod;
    logic [PIX_W-1:0]       gray;
    logic [PIX_W-1:0]       top_px;
    logic [PIX_W-1:0]       mid_px;
    logic [SUM_W-1:0]       x_pos, x_neg, y_pos, y_neg;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;

    assign s1_go   = r_v1 && (!r_v2 || i_ready);
    assign o_ready = !r_v1 || s1_go;

    always_comb begin
        rgb_sum   = SUM_W'(r_red) + SUM_W'(r_green) + SUM_W'(r_blue);
        gray_prod = GRAY_PROD_W'(rgb_sum) * GRAY_PROD_W'(GRAY_MUL);
        gray      = gray_prod[GRAY_SHIFT +: PIX_W];
        top_px    = r_rd[PIX_W-1:0];
        mid_px    = r_rd[2*PIX_W-1:PIX_W];
        // window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
        x_pos = SUM_W'(top_px) + {1'b0, mid_px, 1'b0} + SUM_W'(gray);
        x_neg = SUM_W'(r_win[0]) + {1'b0, r_win[1], 1'b0} + SUM_W'(r_win[2]);
        y_pos = SUM_W'(r_win[2]) + {1'b0, r_win[5], 1'b0} + SUM_W'(gray);
        y_neg = SUM_W'(r_win[0]) + {1'b0, r_win[3], 1'b0} + SUM_W'(top_px);
        gx    = GRAD_W'(GRAD_W'(x_pos) - GRAD_W'(x_neg));
        gy    = GRAD_W'(GRAD_W'(y_pos) - GRAD_W'(y_neg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_load) begin
                r_v1 <= 1'b1;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end
            if (s1_go) begin
                r_v2 <= 1'b1;
            end else if (i_ready) begin
                r_v2 <= 1'b0;
            end
            if (s1_go && r_ctl1.is_pixel) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top_px;
                r_win[4] <= mid_px;
                r_win[5] <= gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl1  <= i_ctl;
            r_idx1  <= i_idx;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_rd    <= r_mem[i_idx];
        end
        if (s1_go) begin
            r_ctl2 <= r_ctl1;
            r_gx   <= gx;
            r_gy   <= gy;
            if (r_ctl1.is_pixel) begin
                r_mem[r_idx1] <= {gray, mid_px};
            end
        end
    end

    assign o_valid = r_v2;
    assign o_ctl   = r_ctl2;
    assign o_gx    = r_gx;
    assign o_gy    = r_gy;

endmodule

### sv/set_mag.sv
`timescale 1ns / 1ps

// Squared magnitude against squared threshold (border items take the border value), then the output register.
module set_mag import set_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_ctl                     i_ctl,
    input  logic signed [GRAD_W-1:0] i_gx,
    input  logic signed [GRAD_W-1:0] i_gy,
    input  logic [MAG_W-1:0]         i_thr2,
    input  logic [PIX_W-1:0]         i_border,
    set_res_if.source                o_res
);

    logic                     r_ov;
    logic [PIX_W-1:0]         r_pix;
    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         r_col;
    logic                     r_last;

    logic                     slot_free;
    logic                     take;
    logic signed [MAG_W-1:0]  sq_x;
    logic signed [MAG_W-1:0]  sq_y;
    logic [MAG_W-1:0]         mag2;
    logic [PIX_W-1:0]         pix;

    assign slot_free = !r_ov || o_res.ready;
    assign o_ready   = slot_free;
    assign take      = i_valid && slot_free && (i_ctl.kind != KIND_NONE);

    always_comb begin
        sq_x = i_gx * i_gx;
        sq_y = i_gy * i_gy;
        mag2 = MAG_W'(sq_x) + MAG_W'(sq_y);
        case (i_ctl.kind)
            KIND_SOBEL:  pix = (mag2 > i_thr2) ? EDGE_VAL : FLAT_VAL;
            KIND_BORDER: pix = i_border;
            default:     pix = i_border;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (take) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pix  <= pix;
            r_row  <= i_ctl.row;
            r_col  <= i_ctl.col;
            r_last <= i_ctl.last;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.edge_pixel = r_pix;
    assign o_res.out_row    = r_row;
    assign o_res.out_col    = r_col;
    assign o_res.frame_last = r_last;

endmodule

### sv/sobel_edge_threshold.sv
// Channel   Dir  Payload                                   Accepted when
// i_pix     in   command, red, green, blue                 valid && ready
// o_res     out  edge_pixel, out_row, out_col, frame_last  valid && ready
// i_cfg     in   index, data (frame_width .. border_value) valid && ready (ready always 1)
//
// One item per clock when neither side stalls; an item goes through the stage 1,
// stage 2 and output registers. The line store takes one read at accept and one write
// as the item leaves stage 1, so the window never waits on the memory.
// Reset: synchronous, active low; no item is taken in the first cycle after it.
// A frame_width write starts a recompute of the output position, one bit a
// cycle; no item is taken until it ends.
// Any config write blocks items in the next cycle while the frame size settles.
`timescale 1ns / 1ps
`include "sobel_edge_threshold_macros.svh"

module sobel_edge_threshold import set_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    set_pix_if.sink   i_pix,
    set_res_if.source o_res,
    set_cfg_if.sink   i_cfg
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WMAX = (MAX_WIDTH < (1 << FW_W) - 1) ? MAX_WIDTH : (1 << FW_W) - 1;
    // output count never needs more than max width * max height
    localparam int OCW  = $clog2(WMAX * ((1 << FH_W) - 1) + 1);
    localparam int CMPW = OCW + 1;
    localparam int PRW  = FW_W + FH_W;

    // configuration
    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;
    logic [THR_W-1:0] r_thr;
    logic [PIX_W-1:0] r_bv;
    logic             r_wr_d;       // config written last cycle (set out of reset too)
    logic             r_div_start;
    logic [OCW-1:0]   r_total;      // effective width * height
    logic [MAG_W-1:0] r_thr2;

    // input side position and output bookkeeping
    logic [FH_W-1:0]  r_in_row;
    logic [CW-1:0]    r_in_col;
    logic             r_tail;       // last input pixel seen, outputs still owed
    logic [OCW-1:0]   r_oc;
    logic [OCW-1:0]   r_ro;
    logic [CW-1:0]    r_co;

    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [PRW-1:0]   total_prod;
    logic             cfg_acc;
    logic             in_acc;
    logic             grad_ready;

    logic             s0_drain;
    logic             s0_produce;
    logic             s0_emit;
    logic             s0_inner;
    logic             s0_last;
    t_ctl             s0_ctl;

    logic [OCW-1:0]   n_oc;
    logic [OCW-1:0]   n_ro;
    logic [CW-1:0]    n_co;
    logic             n_tail;
    logic [FH_W-1:0]  n_in_row;
    logic [CW-1:0]    n_in_col;

    t_div_stat        div_stat;
    logic [OCW-1:0]   div_quo;
    logic [FW_W-1:0]  div_rem;

    logic             g_valid;
    logic             m_ready;
    t_ctl             g_ctl;
    logic signed [GRAD_W-1:0] g_gx;
    logic signed [GRAD_W-1:0] g_gy;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    always_comb begin
        if (r_fw < FW_W'(MIN_DIM)) begin
            w_eff = FW_W'(MIN_DIM);
        end else if (r_fw > FW_W'(WMAX)) begin
            w_eff = FW_W'(WMAX);
        end else begin
            w_eff = r_fw;
        end
        h_eff      = (r_fh < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : r_fh;
        total_prod = PRW'(w_eff) * PRW'(h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw        <= FW_RST;
            r_fh        <= FH_RST;
            r_thr       <= THR_RST;
            r_bv        <= BV_RST;
            r_wr_d      <= 1'b1;
            r_div_start <= 1'b0;
        end else begin
            r_wr_d      <= cfg_acc;
            r_div_start <= cfg_acc && (i_cfg.index == REG_FRAME_WIDTH);
            if (cfg_acc) begin
                case (i_cfg.index)
                    REG_FRAME_WIDTH:    r_fw  <= i_cfg.data[FW_W-1:0];
                    REG_FRAME_HEIGHT:   r_fh  <= i_cfg.data[FH_W-1:0];
                    REG_EDGE_THRESHOLD: r_thr <= i_cfg.data[THR_W-1:0];
                    REG_BORDER_VALUE:   r_bv  <= i_cfg.data[PIX_W-1:0];
                    default:            r_bv  <= r_bv;
                endcase
            end
        end
    end

    // derived values, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_total <= OCW'(total_prod);
        r_thr2  <= MAG_W'(r_thr) * MAG_W'(r_thr);
    end

    // output row/column = out_count / width, out_count % width after a resize
    set_div #(
        .NUM_W (OCW),
        .DEN_W (FW_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_oc),
        .i_den   (w_eff),
        .o_stat  (div_stat),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // ---------------------------------------------------------------- stage 0
    assign i_pix.ready = !r_wr_d && !r_div_start && !div_stat.busy && !div_stat.done
                         && grad_ready;
    assign in_acc      = i_pix.valid && i_pix.ready;

    always_comb begin
        // a pixel arriving while the tail is owed is treated as a drain item
        s0_drain   = (i_pix.command == CMD_DRAIN) || r_tail;
        s0_produce = (r_in_row >= FH_W'(2)) || ((r_in_row == FH_W'(1)) && (r_in_col != '0));
        s0_emit    = s0_drain ? r_tail : s0_produce;
        s0_inner   = (r_ro != '0) && ((CMPW'(r_ro) + CMPW'(1)) < CMPW'(h_eff))
                     && (r_co != '0) && ((CMPW'(r_co) + CMPW'(1)) < CMPW'(w_eff));
        s0_last    = (CMPW'(r_oc) + CMPW'(1)) >= CMPW'(r_total);

        s0_ctl.is_pixel = !s0_drain;
        if (!s0_emit) begin
            s0_ctl.kind = KIND_NONE;
        end else if (!s0_drain && s0_inner) begin
            s0_ctl.kind = KIND_SOBEL;
        end else begin
            s0_ctl.kind = KIND_BORDER;
        end
        s0_ctl.row  = ROW_W'(r_ro);
        s0_ctl.col  = COL_W'(r_co);
        s0_ctl.last = s0_last;

        n_oc     = r_oc;
        n_ro     = r_ro;
        n_co     = r_co;
        n_tail   = r_tail;
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        if (s0_emit) begin
            if (s0_last) begin
                n_oc   = '0;
                n_ro   = '0;
                n_co   = '0;
                n_tail = 1'b0;
            end else begin
                n_oc = r_oc + OCW'(1);
                if ((CMPW'(r_co) + CMPW'(1)) >= CMPW'(w_eff)) begin
                    n_co = '0;
                    n_ro = r_ro + OCW'(1);
                end else begin
                    n_co = r_co + CW'(1);
                end
            end
        end
        if (!s0_drain) begin
            if ((CMPW'(r_in_col) + CMPW'(1)) >= CMPW'(w_eff)) begin
                n_in_col = '0;
                if ((CMPW'(r_in_row) + CMPW'(1)) >= CMPW'(h_eff)) begin
                    n_in_row = '0;
                    n_tail   = 1'b1;
                end else begin
                    n_in_row = r_in_row + FH_W'(1);
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
            r_tail   <= 1'b0;
            r_oc     <= '0;
            r_ro     <= '0;
            r_co     <= '0;
        end else begin
            if (div_stat.done) begin
                r_ro <= div_quo;
                r_co <= CW'(div_rem);
            end
            if (in_acc) begin
                r_in_row <= n_in_row;
                r_in_col <= n_in_col;
                r_tail   <= n_tail;
                r_oc     <= n_oc;
                r_ro     <= n_ro;
                r_co     <= n_co;
            end
        end
    end

    // ------------------------------------------------------ stages 1, 2, out
    set_grad #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .o_ready (grad_ready),
        .i_ctl   (s0_ctl),
        .i_idx   (r_in_col),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (g_valid),
        .i_ready (m_ready),
        .o_ctl   (g_ctl),
        .o_gx    (g_gx),
        .o_gy    (g_gy)
    );

    set_mag u_mag (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (g_valid),
        .o_ready  (m_ready),
        .i_ctl    (g_ctl),
        .i_gx     (g_gx),
        .i_gy     (g_gy),
        .i_thr2   (r_thr2),
        .i_border (r_bv),
        .o_res    (o_res)
    );

    // ---------------------------------------------------------------- checks
    `SET_ASSERT_IMP(a_tail_at_origin, i_clk, i_rst_n, r_tail, (r_in_row == '0) && (r_in_col == '0), "tail owed but input position not at frame start")
    `SET_ASSERT_IMP(a_col_in_range, i_clk, i_rst_n, !r_wr_d && !r_div_start && !div_stat.busy && !div_stat.done, CMPW'(r_co) < CMPW'(w_eff), "output column not below width")
    `SET_ASSERT_NXT(a_last_clears, i_clk, i_rst_n, in_acc && s0_emit && s0_last, (r_oc == '0) && (r_ro == '0) && (r_co == '0), "output count not cleared after frame end")
    `SET_ASSERT_IMP(a_div_quiet, i_clk, i_rst_n, div_stat.busy, r_oc == $past(r_oc), "output count moved during position recompute")

endmodule
